// File: hw/rtl/pgtg_pkg.sv
`timescale 1ns / 1ps
// Package for the polar go-to-goal controller.
// Holds payload structs, register index codes, CORDIC constants and widths.
// No dependencies.
package pgtg_pkg;

   localparam int DATA_W    = 32;
   localparam int STOP_W    = 31;
   localparam int CSR_IDX_W = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GOAL_X             = 3'd0,
      CSR_GOAL_Y             = 3'd1,
      CSR_GOAL_HEADING       = 3'd2,
      CSR_GAIN_DISTANCE      = 3'd3,
      CSR_GAIN_BEARING       = 3'd4,
      CSR_GAIN_FINAL_HEADING = 3'd5,
      CSR_STOP_RADIUS        = 3'd6
   } csr_addr_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] pos_x;
      logic signed [DATA_W-1:0] pos_y;
      logic signed [DATA_W-1:0] heading;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] forward_speed;
      logic signed [DATA_W-1:0] turn_rate;
      logic                     at_goal;
   } rsp_type;

   // atan(2^-i) and pi/2 in Q32
   localparam logic [33:0] HALFPI_Q32 = 34'd6746518852;
   localparam logic [27:0] INVK_Q28   = 28'd163008218;

   localparam logic [33:0] ATAN_Q32 [0:31] = '{
      34'd3373259426, 34'd1991351318, 34'd1052175346, 34'd534100635,
      34'd268086748,  34'd134174063,  34'd67103403,   34'd33553749,
      34'd16777131,   34'd8388597,    34'd4194303,    34'd2097152,
      34'd1048576,    34'd524288,     34'd262144,     34'd131072,
      34'd65536,      34'd32768,      34'd16384,      34'd8192,
      34'd4096,       34'd2048,       34'd1024,       34'd512,
      34'd256,        34'd128,        34'd64,         34'd32,
      34'd16,         34'd8,          34'd4,          34'd2
   };

   // Q32 angle rounded to nearest at frac fraction bits
   function automatic logic [33:0] q32_to_fx(input logic [33:0] t, input int frac);
      logic [34:0] s;
      s = {1'b0, t} + (35'd1 << (31 - frac));
      return 34'(s >> (32 - frac));
   endfunction

endpackage

// File: hw/rtl/polar_go_to_goal_control.sv
`timescale 1ns / 1ps
// Polar go-to-goal drive controller, fully pipelined CORDIC plus gain multipliers.
// Depends on pgtg_pkg.
//
// Usage:
//  - req channel: one pose transaction (pos_x, pos_y, heading, Q format with
//    FRAC_BITS fraction bits) per accepted valid/stall handshake.
//  - rsp channel: one drive command transaction per pose, in order.
//  - csr port: goal, gains and stop radius; write only while the block is idle.
//  - One pose per cycle is sustained while rsp_stall stays low.
//  - Depth: difference, pre-rotation, one register stage per CORDIC iteration,
//    magnitude scaling, rounding, the gain multipliers, the sum and saturation.
//  - Each stage has its own valid bit; a stalled output holds its transaction
//    while earlier stages keep filling empty slots, so req_stall only rises
//    once every stage is occupied.
//  - Synchronous reset empties the pipeline and loads the default goal
//    (1, 1, 0), gains (0.025, 0.03, -0.0125) and stop radius 0.3.
module polar_go_to_goal_control #(
   parameter int FRAC_BITS    = 16,
   parameter int CORDIC_STEPS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  pgtg_pkg::req_type               req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output pgtg_pkg::rsp_type               rsp_data,
   input  logic                            csr_write_en,
   input  logic [pgtg_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [pgtg_pkg::DATA_W-1:0]     csr_wdata
);
   import pgtg_pkg::*;

   localparam int DW  = DATA_W + 1;   // goal - pos
   localparam int CW  = 36;           // CORDIC x/y
   localparam int ZW  = 32;           // CORDIC angle
   localparam int MW  = 62;           // x * 1/K
   localparam int RW  = 34;           // rho, unsigned
   localparam int AW  = 34;           // alpha
   localparam int BW  = 36;           // beta
   localparam int PW  = 68;           // gain products
   localparam int SW  = 69;           // product sum

   localparam int NST      = CORDIC_STEPS + 7;
   localparam int ST_DIFF  = 0;
   localparam int ST_CORD0 = 1;
   localparam int ST_MAG   = CORDIC_STEPS + 2;
   localparam int ST_RHO   = CORDIC_STEPS + 3;
   localparam int ST_PROD  = CORDIC_STEPS + 4;
   localparam int ST_SUM   = CORDIC_STEPS + 5;
   localparam int ST_OUT   = CORDIC_STEPS + 6;

   localparam longint ONE_FX = longint'(1) << FRAC_BITS;
   localparam logic signed [DATA_W-1:0] RST_GOAL  = DATA_W'(ONE_FX);
   localparam logic signed [DATA_W-1:0] RST_KRHO  = DATA_W'((25 * ONE_FX + 500) / 1000);
   localparam logic signed [DATA_W-1:0] RST_KALPH = DATA_W'((30 * ONE_FX + 500) / 1000);
   localparam logic signed [DATA_W-1:0] RST_KBETA =
      DATA_W'(-((125 * ONE_FX + 5000) / 10000));
   localparam logic [STOP_W-1:0] RST_STOP = STOP_W'((3 * ONE_FX + 5) / 10);

   localparam logic signed [ZW-1:0] HALFPI_FX = ZW'(q32_to_fx(HALFPI_Q32, FRAC_BITS));
   localparam logic [MW-1:0]        MAG_RND   = MW'(1) << 27;
   localparam logic signed [SW-1:0] OUT_RND   = SW'(1) << (FRAC_BITS - 1);
   localparam logic signed [SW-1:0] SAT_MAX   = SW'(32'sh7fff_ffff);
   localparam logic signed [SW-1:0] SAT_MIN   = -SW'(64'sh8000_0000);

   // configuration registers
   logic signed [DATA_W-1:0] goal_x_ff, goal_y_ff, goal_hd_ff;
   logic signed [DATA_W-1:0] k_rho_ff, k_alpha_ff, k_beta_ff;
   logic [STOP_W-1:0]        stop_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         goal_x_ff  <= RST_GOAL;
         goal_y_ff  <= RST_GOAL;
         goal_hd_ff <= '0;
         k_rho_ff   <= RST_KRHO;
         k_alpha_ff <= RST_KALPH;
         k_beta_ff  <= RST_KBETA;
         stop_ff    <= RST_STOP;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_GOAL_X:             goal_x_ff  <= csr_wdata;
            CSR_GOAL_Y:             goal_y_ff  <= csr_wdata;
            CSR_GOAL_HEADING:       goal_hd_ff <= csr_wdata;
            CSR_GAIN_DISTANCE:      k_rho_ff   <= csr_wdata;
            CSR_GAIN_BEARING:       k_alpha_ff <= csr_wdata;
            CSR_GAIN_FINAL_HEADING: k_beta_ff  <= csr_wdata;
            CSR_STOP_RADIUS:        stop_ff    <= csr_wdata[STOP_W-1:0];
            default: ;
         endcase
      end
   end

   // stage flow control: a stage loads when it is empty or its content moves on
   logic [NST-1:0] vld_ff;
   logic [NST-1:0] rdy;
   logic [NST-1:0] up_v;
   logic [NST-1:0] load;

   assign rdy[NST-1] = !vld_ff[NST-1] || !rsp_stall;
   assign up_v[0]    = req_valid;

   genvar k;
   generate
      for (k = 0; k < NST - 1; k++) begin : g_rdy
         assign rdy[k]    = !vld_ff[k] || rdy[k+1];
         assign up_v[k+1] = vld_ff[k];
      end
   endgenerate

   assign load = rdy & up_v;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int s = 0; s < NST; s++) begin
            if (rdy[s]) begin
               vld_ff[s] <= up_v[s];
            end
         end
      end
   end

   assign req_stall = !rdy[0];
   assign rsp_valid = vld_ff[ST_OUT];

   // difference to goal
   logic signed [DW-1:0]     dx_in, dy_in, dx_ff, dy_ff;
   logic signed [DATA_W-1:0] hd0_ff;

   assign dx_in = DW'(goal_x_ff) - DW'(req_data.pos_x);
   assign dy_in = DW'(goal_y_ff) - DW'(req_data.pos_y);

   always_ff @(posedge clock) begin
      if (load[ST_DIFF]) begin
         dx_ff  <= dx_in;
         dy_ff  <= dy_in;
         hd0_ff <= req_data.heading;
      end
   end

   // CORDIC vectoring: entry 0 is the quadrant pre-rotation, entry i+1 follows step i
   logic signed [CW-1:0]     cx_in [0:CORDIC_STEPS];
   logic signed [CW-1:0]     cy_in [0:CORDIC_STEPS];
   logic signed [ZW-1:0]     cz_in [0:CORDIC_STEPS];
   logic signed [CW-1:0]     cx_ff [0:CORDIC_STEPS];
   logic signed [CW-1:0]     cy_ff [0:CORDIC_STEPS];
   logic signed [ZW-1:0]     cz_ff [0:CORDIC_STEPS];
   logic signed [DATA_W-1:0] chd_ff [0:CORDIC_STEPS];

   always_comb begin
      if (dx_ff < 0) begin
         if (dy_ff >= 0) begin
            cx_in[0] = CW'(dy_ff);
            cy_in[0] = -CW'(dx_ff);
            cz_in[0] = HALFPI_FX;
         end else begin
            cx_in[0] = -CW'(dy_ff);
            cy_in[0] = CW'(dx_ff);
            cz_in[0] = -HALFPI_FX;
         end
      end else begin
         cx_in[0] = CW'(dx_ff);
         cy_in[0] = CW'(dy_ff);
         cz_in[0] = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (load[ST_CORD0]) begin
         cx_ff[0]  <= cx_in[0];
         cy_ff[0]  <= cy_in[0];
         cz_ff[0]  <= cz_in[0];
         chd_ff[0] <= hd0_ff;
      end
   end

   genvar i;
   generate
      for (i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
         localparam logic signed [ZW-1:0] ATAN_FX = ZW'(q32_to_fx(ATAN_Q32[i], FRAC_BITS));
         logic signed [CW-1:0] xs, ys;

         assign xs = cx_ff[i] >>> i;
         assign ys = cy_ff[i] >>> i;

         always_comb begin
            if (cy_ff[i] >= 0) begin
               cx_in[i+1] = cx_ff[i] + ys;
               cy_in[i+1] = cy_ff[i] - xs;
               cz_in[i+1] = cz_ff[i] + ATAN_FX;
            end else begin
               cx_in[i+1] = cx_ff[i] - ys;
               cy_in[i+1] = cy_ff[i] + xs;
               cz_in[i+1] = cz_ff[i] - ATAN_FX;
            end
         end

         always_ff @(posedge clock) begin
            if (load[ST_CORD0+i+1]) begin
               cx_ff[i+1]  <= cx_in[i+1];
               cy_ff[i+1]  <= cy_in[i+1];
               cz_ff[i+1]  <= cz_in[i+1];
               chd_ff[i+1] <= chd_ff[i];
            end
         end
      end
   endgenerate

   // gain correction of the magnitude, bearing error
   logic [MW-1:0]            mag_in, mag_ff;
   logic signed [AW-1:0]     alpha_in, alpha_ff;
   logic signed [DATA_W-1:0] hd1_ff;

   assign mag_in   = MW'(cx_ff[CORDIC_STEPS][RW-1:0]) * MW'(INVK_Q28);
   assign alpha_in = AW'(cz_ff[CORDIC_STEPS]) - AW'(chd_ff[CORDIC_STEPS]);

   always_ff @(posedge clock) begin
      if (load[ST_MAG]) begin
         mag_ff   <= mag_in;
         alpha_ff <= alpha_in;
         hd1_ff   <= chd_ff[CORDIC_STEPS];
      end
   end

   // rho rounding, final heading error
   logic [MW-1:0]        mag_rnd;
   logic [RW-1:0]        rho_in, rho_ff;
   logic signed [BW-1:0] beta_in, beta_ff;
   logic signed [AW-1:0] alpha2_ff;

   assign mag_rnd = mag_ff + MAG_RND;
   assign rho_in  = mag_rnd[MW-1:28];
   assign beta_in = BW'(hd1_ff) - BW'(goal_hd_ff) - BW'(alpha_ff);

   always_ff @(posedge clock) begin
      if (load[ST_RHO]) begin
         rho_ff    <= rho_in;
         beta_ff   <= beta_in;
         alpha2_ff <= alpha_ff;
      end
   end

   // gain products and stop test
   logic signed [RW:0]   rho_s;
   logic signed [PW-1:0] pd_in, pa_in, pb_in, pd_ff, pa_ff, pb_ff;
   logic                 goal_in, goal_p_ff;

   assign rho_s   = {1'b0, rho_ff};
   assign pd_in   = k_rho_ff * rho_s;
   assign pa_in   = k_alpha_ff * alpha2_ff;
   assign pb_in   = k_beta_ff * beta_ff;
   assign goal_in = rho_ff < RW'(stop_ff);

   always_ff @(posedge clock) begin
      if (load[ST_PROD]) begin
         pd_ff     <= pd_in;
         pa_ff     <= pa_in;
         pb_ff     <= pb_in;
         goal_p_ff <= goal_in;
      end
   end

   // sums with rounding
   logic signed [SW-1:0] sp_in, tr_in, sp_ff, tr_ff;
   logic                 goal_s_ff;

   assign sp_in = SW'(pd_ff) + OUT_RND;
   assign tr_in = SW'(pa_ff) + SW'(pb_ff) + OUT_RND;

   always_ff @(posedge clock) begin
      if (load[ST_SUM]) begin
         sp_ff     <= sp_in;
         tr_ff     <= tr_in;
         goal_s_ff <= goal_p_ff;
      end
   end

   // scale down, saturate, zero the command at the goal, output register
   function automatic logic signed [DATA_W-1:0] sat_out(input logic signed [SW-1:0] v);
      logic signed [SW-1:0] sh;
      sh = v >>> FRAC_BITS;
      if (sh > SAT_MAX) begin
         return DATA_W'(SAT_MAX);
      end else if (sh < SAT_MIN) begin
         return DATA_W'(SAT_MIN);
      end
      return sh[DATA_W-1:0];
   endfunction

   rsp_type rsp_in, rsp_ff;

   always_comb begin
      rsp_in.at_goal = goal_s_ff;
      if (goal_s_ff) begin
         rsp_in.forward_speed = '0;
         rsp_in.turn_rate     = '0;
      end else begin
         rsp_in.forward_speed = sat_out(sp_ff);
         rsp_in.turn_rate     = sat_out(tr_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (load[ST_OUT]) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

// File: hw/rtl/pgtg_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the polar go-to-goal controller, bound to the top level.
// Depends on pgtg_pkg and polar_go_to_goal_control.
module pgtg_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input pgtg_pkg::rsp_type rsp_data
);
   import pgtg_pkg::*;

   // stop command carries zero speed and turn
   a_goal_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.at_goal |->
         (rsp_data.forward_speed == '0) && (rsp_data.turn_rate == '0))
      else $error("at_goal transaction with nonzero command");

   // stalled transaction is held
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled rsp transaction changed");

   // reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid after reset");

   // with the output slot empty no stage can be blocked
   a_no_false_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("req_stall with empty output");

endmodule

bind polar_go_to_goal_control pgtg_checker u_pgtg_checker (.*);
